### hdl/fsus_pkg.sv
// ----------------------------------------------------------------------------
// Fair-share user scheduler package
// Shared sizes, codes and types for the scheduler and its queue cells.
// ----------------------------------------------------------------------------
package fsus_pkg;

    localparam int MAX_TASKS = 16;
    localparam int NUM_USERS = 5;

    localparam int ID_W   = 10;
    localparam int USER_W = 3;
    localparam int PRI_W  = 8;
    localparam int TOT_W  = 32;
    localparam int FUNC_W = 2;
    localparam int ERR_W  = 2;

    localparam int LEN_W  = $clog2(MAX_TASKS + 1);
    localparam int UIDX_W = $clog2(NUM_USERS);

    typedef enum logic [FUNC_W-1:0] {
        FN_SCHED  = 2'd0,
        FN_INSERT = 2'd1,
        FN_REMOVE = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK      = 2'd0,
        ERR_EMPTY   = 2'd1,
        ERR_FULL    = 2'd2,
        ERR_MISSING = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHARGE,
        S_SCAN,
        S_PICK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [USER_W-1:0] user;
        logic [PRI_W-1:0]  pri;
    } entry_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic              by_user;
        logic [ID_W-1:0]   id;
        logic [USER_W-1:0] user;
    } key_t;

endpackage

### hdl/fair_share_user_scheduler.sv
// ----------------------------------------------------------------------------
// Fair-share user scheduler
// Runnable queue kept in a row of cells, per-user saturating slice totals,
// the current task and its slice counter.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  input   | in        | in_valid/in_ready  | func, yield_flag, task_id, task_user,
//          |           |                    | task_priority
//  output  | out       | out_valid/out_ready| run_id, run_valid, error_code
//
// Insert, remove and a schedule call that keeps the current task go from the
// execute state straight to the result; a re-pick walks over the user totals,
// one user a cycle, and first passes a charge state when the current task is
// charged. One item is worked on at a time. Reset empties the queue, clears
// all totals and drops the current task. A stalled result holds the block
// until it is taken.
module fair_share_user_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fsus_pkg::FUNC_W-1:0]   func,
    input  logic                          yield_flag,
    input  logic [fsus_pkg::ID_W-1:0]     task_id,
    input  logic [fsus_pkg::USER_W-1:0]   task_user,
    input  logic [fsus_pkg::PRI_W-1:0]    task_priority,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fsus_pkg::ID_W-1:0]     run_id,
    output logic                          run_valid,
    output logic [fsus_pkg::ERR_W-1:0]    error_code
);
    import fsus_pkg::*;

    state_t               state_reg, state_next;
    func_t                func_reg, func_next;
    logic                 yield_reg, yield_next;
    entry_t               in_reg, in_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [TOT_W-1:0]     totals_reg [NUM_USERS];
    logic [TOT_W-1:0]     totals_next [NUM_USERS];
    logic [PRI_W-1:0]     cnt_reg, cnt_next;
    logic [ID_W-1:0]      cur_id_reg, cur_id_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [USER_W-1:0]    chg_user_reg, chg_user_next;
    logic [PRI_W-1:0]     chg_pri_reg, chg_pri_next;
    logic [UIDX_W-1:0]    uidx_reg, uidx_next;
    logic [UIDX_W-1:0]    best_reg, best_next;
    logic [TOT_W-1:0]     best_tot_reg, best_tot_next;
    logic                 best_valid_reg, best_valid_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    logic                 res_valid_reg, res_valid_next;
    err_t                 res_err_reg, res_err_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic                 out_run_reg, out_run_next;
    err_t                 out_err_reg, out_err_next;
    logic                 out_valid_reg, out_valid_next;

    key_t                 key;
    cell_ctl_t            ctl [MAX_TASKS];
    entry_t               ents [MAX_TASKS];
    logic [MAX_TASKS-1:0] hits;
    logic [MAX_TASKS:0]   seen;
    logic [MAX_TASKS-1:0] occ;
    logic                 any_hit;
    entry_t               hit_ent;
    entry_t               load_data;
    logic                 found, keep, do_remove, do_rotate, do_insert, out_free;
    logic [TOT_W:0]       charge_sum;

    assign seen[0] = 1'b0;
    assign any_hit = seen[MAX_TASKS];

    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_cell
        assign occ[i] = (LEN_W'(i) < len_reg);
        fsus_cell u_cell (
            .clk       (clk),
            .ctl       (ctl[i]),
            .key       (key),
            .load_data (load_data),
            .nbr       ((i + 1 < MAX_TASKS) ? ents[(i + 1) % MAX_TASKS] : ents[i]),
            .occ       (occ[i]),
            .seen_in   (seen[i]),
            .ent       (ents[i]),
            .hit       (hits[i]),
            .seen_out  (seen[i + 1])
        );
    end

    always_comb
    begin
        hit_ent = '0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            hit_ent = hit_ent | (hits[i] ? ents[i] : '0);
        end
    end

    always_comb
    begin
        found     = cur_valid_reg & any_hit;
        keep      = ~yield_reg & (cnt_reg != '0) & found;
        do_remove = (state_reg == S_EXEC) && (func_reg == FN_REMOVE) && any_hit;
        do_rotate = (state_reg == S_EXEC) && (func_reg == FN_SCHED) && !keep && found;
        do_insert = (state_reg == S_EXEC) && (func_reg == FN_INSERT)
                    && (len_reg < LEN_W'(MAX_TASKS));
        out_free  = ~out_valid_reg | out_ready;
        load_data = do_rotate ? hit_ent : in_reg;
        charge_sum = {1'b0, totals_reg[UIDX_W'(chg_user_reg)]} + (TOT_W + 1)'(chg_pri_reg);
    end

    always_comb
    begin
        key.by_user = 1'b0;
        key.id      = in_reg.id;
        key.user    = in_reg.user;
        unique case (state_reg)
            S_EXEC:
            begin
                key.id = (func_reg == FN_REMOVE) ? in_reg.id : cur_id_reg;
            end
            S_SCAN:
            begin
                key.by_user = 1'b1;
                key.user    = USER_W'(uidx_reg);
            end
            S_PICK:
            begin
                key.by_user = 1'b1;
                key.user    = USER_W'(best_reg);
            end
            default:
            begin
                key.by_user = 1'b0;
            end
        endcase
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            ctl[i].shift = (do_remove || do_rotate) && seen[i + 1]
                           && (LEN_W'(i + 1) < len_reg);
            ctl[i].load  = (do_insert && (len_reg == LEN_W'(i)))
                           || (do_rotate && (len_reg == LEN_W'(i + 1)));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if ((func_reg == FN_SCHED) && !keep)
                begin
                    state_next = found ? S_CHARGE : S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CHARGE:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (uidx_reg == UIDX_W'(NUM_USERS - 1))
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        func_next       = func_reg;
        yield_next      = yield_reg;
        in_next         = in_reg;
        len_next        = len_reg;
        totals_next     = totals_reg;
        cnt_next        = cnt_reg;
        cur_id_next     = cur_id_reg;
        cur_valid_next  = cur_valid_reg;
        chg_user_next   = chg_user_reg;
        chg_pri_next    = chg_pri_reg;
        uidx_next       = uidx_reg;
        best_next       = best_reg;
        best_tot_next   = best_tot_reg;
        best_valid_next = best_valid_reg;
        res_id_next     = res_id_reg;
        res_valid_next  = res_valid_reg;
        res_err_next    = res_err_reg;
        out_id_next     = out_id_reg;
        out_run_next    = out_run_reg;
        out_err_next    = out_err_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        in_ready        = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next      = func_t'(func);
                    yield_next     = yield_flag;
                    in_next.id     = task_id;
                    in_next.user   = task_user;
                    in_next.pri    = task_priority;
                    res_id_next    = '0;
                    res_valid_next = 1'b0;
                    res_err_next   = ERR_OK;
                end
            end
            S_EXEC:
            begin
                unique case (func_reg)
                    FN_INSERT:
                    begin
                        if (do_insert)
                        begin
                            len_next = len_reg + 1'b1;
                        end
                        else
                        begin
                            res_err_next = ERR_FULL;
                        end
                    end
                    FN_REMOVE:
                    begin
                        if (any_hit)
                        begin
                            len_next = len_reg - 1'b1;
                        end
                        else
                        begin
                            res_err_next = ERR_MISSING;
                        end
                    end
                    FN_SCHED:
                    begin
                        if (keep)
                        begin
                            cnt_next       = cnt_reg - 1'b1;
                            res_id_next    = cur_id_reg;
                            res_valid_next = 1'b1;
                        end
                        else
                        begin
                            chg_user_next   = hit_ent.user;
                            chg_pri_next    = hit_ent.pri;
                            uidx_next       = '0;
                            best_valid_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        res_err_next = ERR_OK;
                    end
                endcase
            end
            S_CHARGE:
            begin
                if (int'(chg_user_reg) < NUM_USERS)
                begin
                    totals_next[UIDX_W'(chg_user_reg)] =
                        charge_sum[TOT_W] ? '1 : charge_sum[TOT_W-1:0];
                end
            end
            S_SCAN:
            begin
                if (any_hit && (!best_valid_reg || (totals_reg[uidx_reg] < best_tot_reg)))
                begin
                    best_next       = uidx_reg;
                    best_tot_next   = totals_reg[uidx_reg];
                    best_valid_next = 1'b1;
                end
                if (uidx_reg != UIDX_W'(NUM_USERS - 1))
                begin
                    uidx_next = uidx_reg + 1'b1;
                end
            end
            S_PICK:
            begin
                if (best_valid_reg)
                begin
                    cur_id_next    = hit_ent.id;
                    cur_valid_next = 1'b1;
                    cnt_next       = (hit_ent.pri == '0) ? '0 : hit_ent.pri - 1'b1;
                    res_id_next    = hit_ent.id;
                    res_valid_next = 1'b1;
                end
                else
                begin
                    cur_valid_next = 1'b0;
                    cnt_next       = '0;
                    res_err_next   = ERR_EMPTY;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_id_next    = res_id_reg;
                    out_run_next   = res_valid_reg;
                    out_err_next   = res_err_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            cnt_reg       <= '0;
            cur_id_reg    <= '0;
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int u = 0; u < NUM_USERS; u++)
            begin
                totals_reg[u] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            cur_id_reg    <= cur_id_next;
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            totals_reg    <= totals_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        yield_reg      <= yield_next;
        in_reg         <= in_next;
        chg_user_reg   <= chg_user_next;
        chg_pri_reg    <= chg_pri_next;
        uidx_reg       <= uidx_next;
        best_reg       <= best_next;
        best_tot_reg   <= best_tot_next;
        best_valid_reg <= best_valid_next;
        res_id_reg     <= res_id_next;
        res_valid_reg  <= res_valid_next;
        res_err_reg    <= res_err_next;
        out_id_reg     <= out_id_next;
        out_run_reg    <= out_run_next;
        out_err_reg    <= out_err_next;
    end

    assign out_valid  = out_valid_reg;
    assign run_id     = out_id_reg;
    assign run_valid  = out_run_reg;
    assign error_code = out_err_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_TASKS))
        else $error("Queue length exceeds the number of cells.");

    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hits))
        else $error("More than one cell claims the first match.");

    a_pick_present: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK) && best_valid_reg |-> any_hit)
        else $error("Chosen user has no queued task.");

    a_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_run_reg |-> out_err_reg == ERR_OK)
        else $error("A chosen task is reported together with an error.");

endmodule

### hdl/fsus_cell.sv
// ----------------------------------------------------------------------------
// Scheduler queue cell
// Holds one queue entry, loads or takes its right neighbor, and joins the
// first-match chain that runs from the head of the queue.
// ----------------------------------------------------------------------------
module fsus_cell (
    input  logic               clk,
    input  fsus_pkg::cell_ctl_t ctl,
    input  fsus_pkg::key_t     key,
    input  fsus_pkg::entry_t   load_data,
    input  fsus_pkg::entry_t   nbr,
    input  logic               occ,
    input  logic               seen_in,
    output fsus_pkg::entry_t   ent,
    output logic               hit,
    output logic               seen_out
);
    import fsus_pkg::*;

    entry_t ent_reg;
    logic   match;

    always_comb
    begin
        match    = key.by_user ? (ent_reg.user == key.user) : (ent_reg.id == key.id);
        hit      = occ & match & ~seen_in;
        seen_out = seen_in | (occ & match);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            ent_reg <= load_data;
        end
        else if (ctl.shift)
        begin
            ent_reg <= nbr;
        end
    end

    assign ent = ent_reg;

endmodule
